// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the framed packet checker.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CFPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("framed packet checker assertion failed");

// Property that is also checked while reset is asserted.
`define CFPC_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("framed packet checker reset assertion failed");

`endif

// ----- sv/cfpc_pkg.sv -----
// Package of the framed packet checker: widths, header bytes, phase and status codes.
// It also holds the bytewise reflected CRC-32 update. No dependencies.
package cfpc_pkg;

   localparam int CMD_W = 32;
   localparam int LEN_W = 16;
   localparam int LENGTH_BITS = 16;
   localparam int FIELD_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] HEADER_WORD = 16'hFFFE;
   localparam logic [7:0] HEADER_HI = HEADER_WORD[15:8];
   localparam logic [7:0] HEADER_LO = HEADER_WORD[7:0];

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [CMD_W-1:0] MAX_COMMAND_RESET = 32'd255;
   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_COMMAND = 2'd0,
      CSR_MAX_LENGTH  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_HDR2 = 3'd1,
      PH_CMD  = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4,
      PH_CRC  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HEADER = 3'd1,
      ST_BAD_CMD    = 3'd2,
      ST_BAD_LEN    = 3'd3,
      ST_BAD_CRC    = 3'd4
   } status_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/cfpc_channels.sv -----
// Valid/ready channel interfaces of the framed packet checker: received bytes in, results out.
// Depends on cfpc_pkg for the field widths.
interface cfpc_req_if;
   import cfpc_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfpc_rsp_if;
   import cfpc_pkg::*;

   logic             valid;
   logic             ready;
   logic [7:0]       data_byte;
   logic             last;
   logic [CMD_W-1:0] frame_command;
   logic [LEN_W-1:0] frame_length;
   logic [2:0]       status;

   modport source (output valid, output data_byte, output last, output frame_command,
                   output frame_length, output status, input ready);
   modport sink (input valid, input data_byte, input last, input frame_command,
                 input frame_length, input status, output ready);
endinterface

// ----- sv/crc_framed_packet_checker.sv -----
// Framed packet checker top level: frame parser, CRC-32 check and result register.
// Depends on cfpc_pkg and the channel interfaces in cfpc_channels.sv.
//
// The block takes one received byte per request and can accept a request in every
// clock cycle. Each frame is the header 0xFF 0xFE, a big-endian 32-bit command, a
// big-endian 32-bit content length, the content and a big-endian CRC-32 of the content.
// Content bytes come out in the cycle after they are accepted, with last low; the frame
// ends with one result with last high and the status (0 ok, 1 bad header, 2 bad command,
// 3 bad length, 4 bad checksum). Bytes outside a frame give no result. The one result
// register sets the pace: a byte is taken whenever that register is empty or is being
// emptied in the same cycle, so the block holds off input only while the result side
// stalls. The limits max_command and max_length are written through the csr port; the user
// must write them only while no frame is in progress, which the block does not enforce.
module crc_framed_packet_checker (
   input  logic                             clock,
   input  logic                             reset,
   cfpc_req_if.sink                         req_chan,
   cfpc_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [cfpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cfpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cfpc_pkg::*;

   logic [CMD_W-1:0]   max_command_ff;
   logic [LEN_W-1:0]   max_length_ff;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [FIELD_W-1:0] command_ff, command_in;
   logic [FIELD_W-1:0] length_ff, length_in;
   logic [31:0]        crc_ff, crc_in;
   logic [31:0]        crc_rx_ff, crc_rx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         data_byte_ff, data_byte_in;
   logic               last_ff, last_in;
   logic [CMD_W-1:0]   frame_command_ff, frame_command_in;
   logic [LEN_W-1:0]   frame_length_ff, frame_length_in;
   status_type         status_ff, status_in;

   logic               accept;
   logic               emit;
   logic [7:0]         b;
   logic [FIELD_W-1:0] command_shift;
   logic [FIELD_W-1:0] length_shift;
   logic [31:0]        crc_shift;
   logic [31:0]        crc_step;
   logic [LEN_W:0]     count_plus;
   logic               field_done;
   logic               length_bad;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;

   assign command_shift = {command_ff[FIELD_W-9:0], b};
   assign length_shift  = {length_ff[FIELD_W-9:0], b};
   assign crc_shift     = {crc_rx_ff[23:0], b};
   assign crc_step      = crc_byte(crc_ff, b);
   assign count_plus    = {1'b0, count_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign field_done    = (count_ff == LEN_W'(3));
   assign length_bad    = (length_shift > {{(FIELD_W-LEN_W){1'b0}}, max_length_ff})
                          || ((length_shift >> LENGTH_BITS) != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_command_ff <= MAX_COMMAND_RESET;
         max_length_ff  <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_COMMAND) begin
            max_command_ff <= csr_wdata[CMD_W-1:0];
         end else if (csr_index == CSR_MAX_LENGTH) begin
            max_length_ff <= csr_wdata[LEN_W-1:0];
         end
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      count_in         = count_ff;
      command_in       = command_ff;
      length_in        = length_ff;
      crc_in           = crc_ff;
      crc_rx_in        = crc_rx_ff;
      emit             = 1'b0;
      data_byte_in     = 8'd0;
      last_in          = 1'b1;
      frame_command_in = command_ff[CMD_W-1:0];
      frame_length_in  = length_ff[LEN_W-1:0];
      status_in        = ST_OK;

      unique case (phase_ff)
         PH_HUNT: begin
            if (b == HEADER_HI) begin
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (b == HEADER_LO) begin
               phase_in   = PH_CMD;
               count_in   = '0;
               command_in = '0;
            end else begin
               emit             = 1'b1;
               frame_command_in = '0;
               frame_length_in  = '0;
               status_in        = ST_BAD_HEADER;
               phase_in         = (b == HEADER_HI) ? PH_HDR2 : PH_HUNT;
               count_in         = '0;
               command_in       = '0;
               length_in        = '0;
               crc_in           = CRC_INIT;
               crc_rx_in        = '0;
            end
         end
         PH_CMD: begin
            command_in = command_shift;
            count_in   = count_plus[LEN_W-1:0];
            if (field_done) begin
               if (command_shift > max_command_ff) begin
                  emit             = 1'b1;
                  frame_command_in = command_shift[CMD_W-1:0];
                  frame_length_in  = '0;
                  status_in        = ST_BAD_CMD;
                  phase_in         = PH_HUNT;
                  count_in         = '0;
                  command_in       = '0;
                  length_in        = '0;
                  crc_in           = CRC_INIT;
                  crc_rx_in        = '0;
               end else begin
                  phase_in  = PH_LEN;
                  count_in  = '0;
                  length_in = '0;
               end
            end
         end
         PH_LEN: begin
            length_in = length_shift;
            count_in  = count_plus[LEN_W-1:0];
            if (field_done) begin
               if (length_bad) begin
                  emit            = 1'b1;
                  frame_length_in = length_shift[LEN_W-1:0];
                  status_in       = ST_BAD_LEN;
                  phase_in        = PH_HUNT;
                  count_in        = '0;
                  command_in      = '0;
                  length_in       = '0;
                  crc_in          = CRC_INIT;
                  crc_rx_in       = '0;
               end else begin
                  count_in  = '0;
                  crc_in    = CRC_INIT;
                  crc_rx_in = '0;
                  phase_in  = (length_shift == '0) ? PH_CRC : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            emit         = 1'b1;
            data_byte_in = b;
            last_in      = 1'b0;
            crc_in       = crc_step;
            count_in     = count_plus[LEN_W-1:0];
            if (count_plus >= {1'b0, length_ff[LEN_W-1:0]}) begin
               phase_in = PH_CRC;
               count_in = '0;
            end
         end
         PH_CRC: begin
            crc_rx_in = crc_shift;
            count_in  = count_plus[LEN_W-1:0];
            if (field_done) begin
               emit       = 1'b1;
               status_in  = ((crc_ff ^ CRC_INIT) == crc_shift) ? ST_OK : ST_BAD_CRC;
               phase_in   = PH_HUNT;
               count_in   = '0;
               command_in = '0;
               length_in  = '0;
               crc_in     = CRC_INIT;
               crc_rx_in  = '0;
            end
         end
         default: begin
            phase_in   = PH_HUNT;
            count_in   = '0;
            command_in = '0;
            length_in  = '0;
            crc_in     = CRC_INIT;
            crc_rx_in  = '0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         command_ff   <= '0;
         length_ff    <= '0;
         crc_ff       <= CRC_INIT;
         crc_rx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            command_ff <= command_in;
            length_ff  <= length_in;
            crc_ff     <= crc_in;
            crc_rx_ff  <= crc_rx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         data_byte_ff     <= data_byte_in;
         last_ff          <= last_in;
         frame_command_ff <= frame_command_in;
         frame_length_ff  <= frame_length_in;
         status_ff        <= status_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_byte     = data_byte_ff;
   assign rsp_chan.last          = last_ff;
   assign rsp_chan.frame_command = frame_command_ff;
   assign rsp_chan.frame_length  = frame_length_ff;
   assign rsp_chan.status        = status_ff;

endmodule

// ----- sv/cfpc_checker.sv -----
// Port-level assertions for the framed packet checker, bound to its top level.
// Depends on cfpc_pkg and assert_macros.svh.
module cfpc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [7:0]                 rsp_data_byte,
   input logic                       rsp_last,
   input logic [cfpc_pkg::CMD_W-1:0] rsp_frame_command,
   input logic [cfpc_pkg::LEN_W-1:0] rsp_frame_length,
   input logic [2:0]                 rsp_status
);
   import cfpc_pkg::*;
   `include "assert_macros.svh"

   // A stalled result stays valid and keeps its data byte, last flag and status.
   `CFPC_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_last) && $stable(rsp_status))

   // Content results always carry an ok status.
   `CFPC_ASSERT(a_content_ok, clock, reset, rsp_valid && !rsp_last |-> rsp_status == ST_OK)

   // End results carry no content byte.
   `CFPC_ASSERT(a_end_no_data, clock, reset, rsp_valid && rsp_last |-> rsp_data_byte == 8'd0)

   // A broken header ends before any command or length has been received.
   `CFPC_ASSERT(a_hdr_empty, clock, reset,
      rsp_valid && rsp_last && rsp_status == ST_BAD_HEADER
         |-> rsp_frame_command == '0 && rsp_frame_length == '0)

   // Reset empties the result register.
   `CFPC_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind crc_framed_packet_checker cfpc_checker u_cfpc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_data_byte     (rsp_chan.data_byte),
   .rsp_last          (rsp_chan.last),
   .rsp_frame_command (rsp_chan.frame_command),
   .rsp_frame_length  (rsp_chan.frame_length),
   .rsp_status        (rsp_chan.status)
);
